/* hw/rtl/imu_tilt_complementary_filter_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the tilt filter core
// Concurrent property wrappers; defined empty when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef IMU_TILT_COMPLEMENTARY_FILTER_CORE_ASSERT_SVH
`define IMU_TILT_COMPLEMENTARY_FILTER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ITF_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ITF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ITF_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define ITF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hw/rtl/itf_pkg.sv */
// ----------------------------------------------------------------------------
// itf_pkg
// Shared types, constants and the arctangent table of the tilt filter core.
// ----------------------------------------------------------------------------
package itf_pkg;

    // angle format: signed, 1/128 degree
    localparam int ANG_W      = 16;
    localparam int ANG_LIMIT  = 23040;
    localparam int RIGHT_ANG  = 11520;

    // corrected sample widths
    localparam int ACC_W      = 15;
    localparam int GYR_W      = 17;

    // CORDIC datapath
    localparam int ATAN_TAB_LEN = 24;
    localparam int ATAN_IDX_W   = $clog2(ATAN_TAB_LEN);
    localparam int VEC_W        = 32;
    localparam int ZACC_W       = 34;
    localparam int CLAMP_IN_W   = 24;

    // blend datapath
    localparam int MUL_A_W    = 18;
    localparam int MUL_B_W    = 25;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int RS_W       = 42;
    localparam int RS_LO_W    = 21;
    localparam int BACC_W     = 62;
    localparam int BLEND_SH   = 40;
    localparam int BLEND_LEN  = 7;
    localparam int BLEND_LAST = 2 * BLEND_LEN - 1;
    localparam int BCNT_W     = 4;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_ALPHA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SCALE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_OFS_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_OFS_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_OFS_Z   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GYR_OFS_X   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GYR_OFS_Y   = 3'd6;

    localparam logic [15:0] ALPHA_RESET = 16'd62582;
    localparam logic [23:0] SCALE_RESET = 24'd150323;

    // multiplier operand select
    typedef enum logic [2:0] {
        MS_RS  = 3'd0,   // rate * scale
        MS_OLD = 3'd1,   // alpha * old estimate
        MS_ANG = 3'd2,   // (1 - alpha) * accel angle
        MS_LO  = 3'd3,   // alpha * low part of rate term
        MS_HI  = 3'd4    // alpha * high part of rate term
    } mul_sel_t;

    // accumulator operation
    typedef enum logic [2:0] {
        AO_NONE    = 3'd0,
        AO_RS_LOAD = 3'd1,
        AO_LOAD24  = 3'd2,
        AO_ADD24   = 3'd3,
        AO_ADD0    = 3'd4,
        AO_ADD21   = 3'd5,
        AO_EST     = 3'd6
    } acc_op_t;

    // controller to datapath command
    typedef struct packed {
        logic                  load_in;
        logic                  cord_init;
        logic                  cord_pitch;
        logic                  cord_step;
        logic [ATAN_IDX_W-1:0] cord_idx;
        logic                  save_roll;
        logic                  save_pitch;
        logic                  blend_pitch;
        mul_sel_t              mul_sel;
        acc_op_t               acc_op;
        logic                  out_load;
    } itf_cmd_t;

    // atan(2^-i) in units of 2^-23 degree
    function automatic logic signed [ZACC_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] i);
        logic signed [ZACC_W-1:0] r;
        case (i)
            5'd0:    r = 34'sd377487360;
            5'd1:    r = 34'sd222843801;
            5'd2:    r = 34'sd117744544;
            5'd3:    r = 34'sd59768969;
            5'd4:    r = 34'sd30000467;
            5'd5:    r = 34'sd15014858;
            5'd6:    r = 34'sd7509261;
            5'd7:    r = 34'sd3754860;
            5'd8:    r = 34'sd1877459;
            5'd9:    r = 34'sd938733;
            5'd10:   r = 34'sd469367;
            5'd11:   r = 34'sd234683;
            5'd12:   r = 34'sd117342;
            5'd13:   r = 34'sd58671;
            5'd14:   r = 34'sd29335;
            5'd15:   r = 34'sd14668;
            5'd16:   r = 34'sd7334;
            5'd17:   r = 34'sd3667;
            5'd18:   r = 34'sd1833;
            5'd19:   r = 34'sd917;
            5'd20:   r = 34'sd458;
            5'd21:   r = 34'sd229;
            5'd22:   r = 34'sd115;
            5'd23:   r = 34'sd57;
            default: r = '0;
        endcase
        return r;
    endfunction

    // saturate to +-180 degrees
    function automatic logic signed [ANG_W-1:0] clamp_ang(
        input logic signed [CLAMP_IN_W-1:0] v);
        logic signed [CLAMP_IN_W-1:0] hi;
        logic signed [CLAMP_IN_W-1:0] lo;
        logic signed [ANG_W-1:0]      r;
        hi = CLAMP_IN_W'(ANG_LIMIT);
        lo = -hi;
        if (v > hi) begin
            r = ANG_W'(ANG_LIMIT);
        end else if (v < lo) begin
            r = -ANG_W'(ANG_LIMIT);
        end else begin
            r = v[ANG_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/imu_tilt_complementary_filter_core.sv */
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter_core
// Complementary tilt filter: CORDIC accel angles blended with gyro rates.
// ----------------------------------------------------------------------------
// Channel   Dir  Width  Contents
// s_axis    in   80     accel x/y/z words, gyro x/y words
// m_axis    out  64     roll, pitch, accel roll, accel pitch
// cfg       in   24     blend_alpha .. gyro_offset_y, index 0..6
//
// From accept to next accept, one request runs two sequential passes of the
// single CORDIC unit (init, rotations and save each), the roll and pitch
// blend steps on the shared blend multiplier and one hand-off state; m_tvalid
// is registered and rises together with the new output register value.
// A new request is taken once the previous result sits in the output
// register; while an older result still waits on m_tready, the hand-off stalls.
// Synchronous active-low reset restores register defaults and zero estimates.
// ----------------------------------------------------------------------------
module imu_tilt_complementary_filter_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // accel_x_word, accel_y_word, accel_z_word, gyro_x_word, gyro_y_word
    input  logic [79:0]                        s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // roll_angle, pitch_angle, accel_roll, accel_pitch
    output logic [63:0]                        m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_we,
    input  logic [itf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [itf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import itf_pkg::*;

`include "imu_tilt_complementary_filter_core_assert.svh"

    itf_cmd_t cmd;

    itf_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    itf_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .out_data  (m_tdata)
    );

    // checks
    `ITF_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "accepted request did not make the core busy")
    `ITF_ASSERT_NEXT(a_load_sets_valid, aclk, aresetn, cmd.out_load, m_tvalid, "result load did not raise m_tvalid")
    `ITF_ASSERT_IMPL(a_est_not_idle, aclk, aresetn, cmd.acc_op == AO_EST, !s_tready, "estimate written while idle")
    `ITF_ASSERT_IMPL(a_roll_range, aclk, aresetn, m_tvalid, ($signed(m_tdata[15:0]) <= 16'sd23040) && ($signed(m_tdata[15:0]) >= -16'sd23040), "roll outside 180 degrees")

endmodule

/* hw/rtl/itf_cordic.sv */
// ----------------------------------------------------------------------------
// itf_cordic
// Iterative vectoring CORDIC, atan2 in 1/128 deg: one rotation per step cycle.
// ----------------------------------------------------------------------------
module itf_cordic (
    input  logic                               aclk,
    input  logic                               init,
    input  logic                               step,
    input  logic [itf_pkg::ATAN_IDX_W-1:0]     idx,
    input  logic signed [itf_pkg::ACC_W-1:0]   num_in,
    input  logic signed [itf_pkg::ACC_W-1:0]   den_in,
    output logic signed [itf_pkg::ANG_W-1:0]   angle
);
    import itf_pkg::*;

    localparam int QSH = 16;

    logic signed [VEC_W-1:0]  vx_reg;
    logic signed [VEC_W-1:0]  vy_reg;
    logic signed [ZACC_W-1:0] z_reg;
    logic                     zero_reg;

    logic signed [ACC_W-1:0]  num_f;
    logic signed [ACC_W-1:0]  den_f;
    logic signed [ZACC_W-1:0] z_start;
    logic signed [VEC_W-1:0]  sh_x;
    logic signed [VEC_W-1:0]  sh_y;
    logic signed [ZACC_W-1:0] at;
    logic signed [ZACC_W-1:0] z_rnd;

    // fold left half plane by 180 degrees
    always_comb begin
        z_start = '0;
        num_f   = num_in;
        den_f   = den_in;
        if (den_in < 0) begin
            z_start = (num_in >= 0) ? ZACC_W'(ANG_LIMIT * 65536) : -ZACC_W'(ANG_LIMIT * 65536);
            num_f   = -num_in;
            den_f   = -den_in;
        end
    end

    assign sh_x = vx_reg >>> idx;
    assign sh_y = vy_reg >>> idx;
    assign at   = atan_entry(idx);

    // rotation step
    always_ff @(posedge aclk) begin
        if (init) begin
            vx_reg   <= VEC_W'(den_f) <<< 14;
            vy_reg   <= VEC_W'(num_f) <<< 14;
            z_reg    <= z_start;
            zero_reg <= (num_in == 0) && (den_in == 0);
        end else if (step) begin
            if (vy_reg > 0) begin
                vx_reg <= vx_reg + sh_y;
                vy_reg <= vy_reg - sh_x;
                z_reg  <= z_reg + at;
            end else begin
                vx_reg <= vx_reg - sh_y;
                vy_reg <= vy_reg + sh_x;
                z_reg  <= z_reg - at;
            end
        end
    end

    // round half up to 1/128 degree and saturate
    assign z_rnd = z_reg + ZACC_W'(32768);
    assign angle = zero_reg ? '0 : clamp_ang(CLAMP_IN_W'(z_rnd >>> QSH));

endmodule

/* hw/rtl/itf_datapath.sv */
// ----------------------------------------------------------------------------
// itf_datapath
// Config registers, sample correction, CORDIC, blend MAC and output register.
// ----------------------------------------------------------------------------
module itf_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [itf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [itf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [79:0]                        in_data,
    input  itf_pkg::itf_cmd_t                  cmd,
    output logic [63:0]                        out_data
);
    import itf_pkg::*;

    // configuration
    logic [15:0]        alpha_reg;
    logic [23:0]        scale_reg;
    logic signed [13:0] aofs_x_reg;
    logic signed [13:0] aofs_y_reg;
    logic signed [13:0] aofs_z_reg;
    logic signed [15:0] gofs_x_reg;
    logic signed [15:0] gofs_y_reg;

    // sample and state
    logic signed [ACC_W-1:0]  ax_reg;
    logic signed [ACC_W-1:0]  ay_reg;
    logic signed [ACC_W-1:0]  az_reg;
    logic signed [GYR_W-1:0]  gx_reg;
    logic signed [GYR_W-1:0]  gy_reg;
    logic signed [ANG_W-1:0]  acc_r_reg;
    logic signed [ANG_W-1:0]  acc_p_reg;
    logic signed [ANG_W-1:0]  roll_est_reg;
    logic signed [ANG_W-1:0]  pitch_est_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [RS_W-1:0]   rs_reg;
    logic signed [BACC_W-1:0] bacc_reg;
    logic [63:0]              out_reg;

    logic signed [15:0]       wx, wy, wz, wgx, wgy;
    logic signed [ACC_W-1:0]  cnum, cden;
    logic signed [ANG_W-1:0]  cord_angle;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_A_W-1:0] wg;
    logic signed [MUL_A_W-1:0] wa;
    logic signed [ANG_W-1:0]  old_sel;
    logic signed [ANG_W-1:0]  ang_sel;
    logic signed [GYR_W-1:0]  rate_sel;
    logic signed [BACC_W-1:0] bacc_rnd;
    logic signed [ANG_W-1:0]  blend_res;

    assign wx  = in_data[15:0];
    assign wy  = in_data[31:16];
    assign wz  = in_data[47:32];
    assign wgx = in_data[63:48];
    assign wgy = in_data[79:64];

    // configuration write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg  <= ALPHA_RESET;
            scale_reg  <= SCALE_RESET;
            aofs_x_reg <= '0;
            aofs_y_reg <= '0;
            aofs_z_reg <= '0;
            gofs_x_reg <= '0;
            gofs_y_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_BLEND_ALPHA: alpha_reg  <= cfg_data[15:0];
                CFG_GYRO_SCALE:  scale_reg  <= cfg_data;
                CFG_ACC_OFS_X:   aofs_x_reg <= cfg_data[13:0];
                CFG_ACC_OFS_Y:   aofs_y_reg <= cfg_data[13:0];
                CFG_ACC_OFS_Z:   aofs_z_reg <= cfg_data[13:0];
                CFG_GYR_OFS_X:   gofs_x_reg <= cfg_data[15:0];
                CFG_GYR_OFS_Y:   gofs_y_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sample capture with offset removal
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            ax_reg <= ACC_W'(wx >>> 2) - ACC_W'(aofs_x_reg);
            ay_reg <= ACC_W'(wy >>> 2) - ACC_W'(aofs_y_reg);
            az_reg <= ACC_W'(wz >>> 2) - ACC_W'(aofs_z_reg);
            gx_reg <= GYR_W'(wgx) - GYR_W'(gofs_x_reg);
            gy_reg <= GYR_W'(wgy) - GYR_W'(gofs_y_reg);
        end
    end

    // CORDIC operand pair: pitch depends on accel roll quadrant
    always_comb begin
        if (!cmd.cord_pitch) begin
            cnum = ay_reg;
            cden = az_reg;
        end else begin
            cnum = ax_reg;
            if (acc_r_reg > ANG_W'(RIGHT_ANG)) begin
                cden = ay_reg;
            end else if (acc_r_reg < -ANG_W'(RIGHT_ANG)) begin
                cden = -az_reg;
            end else begin
                cden = az_reg;
            end
        end
    end

    itf_cordic u_cordic (
        .aclk   (aclk),
        .init   (cmd.cord_init),
        .step   (cmd.cord_step),
        .idx    (cmd.cord_idx),
        .num_in (cnum),
        .den_in (cden),
        .angle  (cord_angle)
    );

    always_ff @(posedge aclk) begin
        if (cmd.save_roll) begin
            acc_r_reg <= cord_angle;
        end
        if (cmd.save_pitch) begin
            acc_p_reg <= cord_angle;
        end
    end

    // blend operand select
    assign wg       = MUL_A_W'(alpha_reg);
    assign wa       = MUL_A_W'(65536) - wg;
    assign old_sel  = cmd.blend_pitch ? pitch_est_reg : roll_est_reg;
    assign ang_sel  = cmd.blend_pitch ? acc_p_reg : acc_r_reg;
    assign rate_sel = cmd.blend_pitch ? gy_reg : gx_reg;

    always_comb begin
        case (cmd.mul_sel)
            MS_RS: begin
                mul_a = MUL_A_W'(rate_sel);
                mul_b = MUL_B_W'({1'b0, scale_reg});
            end
            MS_OLD: begin
                mul_a = wg;
                mul_b = MUL_B_W'(old_sel);
            end
            MS_ANG: begin
                mul_a = wa;
                mul_b = MUL_B_W'(ang_sel);
            end
            MS_LO: begin
                mul_a = wg;
                mul_b = MUL_B_W'({1'b0, rs_reg[RS_LO_W-1:0]});
            end
            MS_HI: begin
                mul_a = wg;
                mul_b = MUL_B_W'($signed(rs_reg[RS_W-1:RS_LO_W]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // registered multiplier
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // round half up, saturate
    assign bacc_rnd  = bacc_reg + (BACC_W'(1) <<< (BLEND_SH - 1));
    assign blend_res = clamp_ang(CLAMP_IN_W'(bacc_rnd >>> BLEND_SH));

    // blend accumulator
    always_ff @(posedge aclk) begin
        case (cmd.acc_op)
            AO_RS_LOAD: rs_reg   <= RS_W'(prod_reg);
            AO_LOAD24:  bacc_reg <= BACC_W'(prod_reg) <<< 24;
            AO_ADD24:   bacc_reg <= bacc_reg + (BACC_W'(prod_reg) <<< 24);
            AO_ADD0:    bacc_reg <= bacc_reg + BACC_W'(prod_reg);
            AO_ADD21:   bacc_reg <= bacc_reg + (BACC_W'(prod_reg) <<< RS_LO_W);
            default: ;
        endcase
    end

    // filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roll_est_reg  <= '0;
            pitch_est_reg <= '0;
        end else if (cmd.acc_op == AO_EST) begin
            if (cmd.blend_pitch) begin
                pitch_est_reg <= blend_res;
            end else begin
                roll_est_reg <= blend_res;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= {acc_p_reg, acc_r_reg, pitch_est_reg, roll_est_reg};
        end
    end

    assign out_data = out_reg;

endmodule

/* hw/rtl/itf_ctrl.sv */
// ----------------------------------------------------------------------------
// itf_ctrl
// Sequencer: roll CORDIC, pitch CORDIC, two blend passes, result hand-off.
// ----------------------------------------------------------------------------
module itf_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output itf_pkg::itf_cmd_t cmd
);
    import itf_pkg::*;

    localparam int STEPS = (CORDIC_STEPS > ATAN_TAB_LEN) ? ATAN_TAB_LEN : CORDIC_STEPS;
    localparam int CNT_W = $clog2(STEPS);

    // blend micro steps within one angle
    localparam logic [BCNT_W-1:0] BS_MUL_RS = 4'd0;
    localparam logic [BCNT_W-1:0] BS_OLD    = 4'd1;
    localparam logic [BCNT_W-1:0] BS_ANG    = 4'd2;
    localparam logic [BCNT_W-1:0] BS_LO     = 4'd3;
    localparam logic [BCNT_W-1:0] BS_HI     = 4'd4;
    localparam logic [BCNT_W-1:0] BS_ADD_HI = 4'd5;
    localparam logic [BCNT_W-1:0] BS_EST    = 4'd6;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CINIT = 6'b000010,
        ST_CITER = 6'b000100,
        ST_CSAVE = 6'b001000,
        ST_BLEND = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [BCNT_W-1:0] bcnt_reg, bcnt_next;
    logic              phase_reg, phase_next;
    logic              out_valid_reg, out_valid_next;
    logic              bpitch;
    logic [BCNT_W-1:0] bstep;

    assign bpitch = (bcnt_reg >= BCNT_W'(BLEND_LEN));
    assign bstep  = bpitch ? (bcnt_reg - BCNT_W'(BLEND_LEN)) : bcnt_reg;

    // next state and command decode
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        bcnt_next      = bcnt_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.mul_sel    = MS_RS;
        cmd.acc_op     = AO_NONE;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_in = 1'b1;
                    phase_next  = 1'b0;
                    state_next  = ST_CINIT;
                end
            end
            ST_CINIT: begin
                cmd.cord_init  = 1'b1;
                cmd.cord_pitch = phase_reg;
                cnt_next       = '0;
                state_next     = ST_CITER;
            end
            ST_CITER: begin
                cmd.cord_step = 1'b1;
                cmd.cord_idx  = ATAN_IDX_W'(cnt_reg);
                if (cnt_reg == CNT_W'(STEPS - 1)) begin
                    state_next = ST_CSAVE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_CSAVE: begin
                if (phase_reg) begin
                    cmd.save_pitch = 1'b1;
                    bcnt_next      = '0;
                    state_next     = ST_BLEND;
                end else begin
                    cmd.save_roll = 1'b1;
                    phase_next    = 1'b1;
                    state_next    = ST_CINIT;
                end
            end
            ST_BLEND: begin
                cmd.blend_pitch = bpitch;
                case (bstep)
                    BS_MUL_RS: cmd.mul_sel = MS_RS;
                    BS_OLD: begin
                        cmd.mul_sel = MS_OLD;
                        cmd.acc_op  = AO_RS_LOAD;
                    end
                    BS_ANG: begin
                        cmd.mul_sel = MS_ANG;
                        cmd.acc_op  = AO_LOAD24;
                    end
                    BS_LO: begin
                        cmd.mul_sel = MS_LO;
                        cmd.acc_op  = AO_ADD24;
                    end
                    BS_HI: begin
                        cmd.mul_sel = MS_HI;
                        cmd.acc_op  = AO_ADD0;
                    end
                    BS_ADD_HI: cmd.acc_op = AO_ADD21;
                    BS_EST:    cmd.acc_op = AO_EST;
                    default: ;
                endcase
                if (bcnt_reg == BCNT_W'(BLEND_LAST)) begin
                    state_next = ST_FIN;
                end else begin
                    bcnt_next = bcnt_reg + 1'b1;
                end
            end
            ST_FIN: begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            bcnt_reg      <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            bcnt_reg      <= bcnt_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* tb/tilt_filter_checker.sv */
// ----------------------------------------------------------------------------
// tilt_filter_checker
// Watches the request, result and register-write ports of the tilt filter
// core. It keeps its own copy of the registers and of the roll and pitch
// estimates, works out the expected result of every accepted request, and
// compares each accepted result with the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module tilt_filter_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // accel_x_word, accel_y_word, accel_z_word, gyro_x_word, gyro_y_word
    input  logic [79:0]                    s_tdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // roll_angle, pitch_angle, accel_roll, accel_pitch
    input  logic [63:0]                    m_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_we,
    input  logic [itf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [itf_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTS = 40;

    // register copies
    logic [15:0]        alpha;
    logic [23:0]        rate_scale;
    logic signed [13:0] ofs_ax, ofs_ay, ofs_az;
    logic signed [15:0] ofs_gx, ofs_gy;

    // filter state
    logic signed [15:0] roll_est, pitch_est;

    // atan(2^-i) in 2^-23 degree
    longint atan_step_deg [24];
    string  field_name [4];

    logic [63:0] tilt_expect_q [$];
    int          result_idx;

    initial begin
        atan_step_deg = '{377487360, 222843801, 117744544, 59768969, 30000467,
                          15014858, 7509261, 3754860, 1877459, 938733, 469367,
                          234683, 117342, 58671, 29335, 14668, 7334, 3667,
                          1833, 917, 458, 229, 115, 57};
        field_name = '{"roll_angle", "pitch_angle", "accel_roll", "accel_pitch"};
    end

    function automatic longint sat_angle(longint v);
        if (v > itf_pkg::ANG_LIMIT) return itf_pkg::ANG_LIMIT;
        if (v < -itf_pkg::ANG_LIMIT) return -itf_pkg::ANG_LIMIT;
        return v;
    endfunction

    // vectoring CORDIC, result in 1/128 degree
    function automatic longint tilt_atan2(longint num, longint den);
        longint vx, vy, nx, zacc;
        zacc = 0;
        if (num == 0 && den == 0) return 0;
        // left half plane: turn by 180 degrees first
        if (den < 0) begin
            zacc = (num >= 0) ? longint'(itf_pkg::ANG_LIMIT) * 65536
                              : -longint'(itf_pkg::ANG_LIMIT) * 65536;
            den = -den;
            num = -num;
        end
        vx = den * 16384;
        vy = num * 16384;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            if (vy > 0) begin
                nx = vx + (vy >>> i);
                vy = vy - (vx >>> i);
                zacc += atan_step_deg[i];
            end else begin
                nx = vx - (vy >>> i);
                vy = vy + (vx >>> i);
                zacc -= atan_step_deg[i];
            end
            vx = nx;
        end
        return sat_angle((zacc + 32768) >>> 16);
    endfunction

    // alpha*(old + rate*scale) + (1-alpha)*accel angle, rounded half up
    function automatic longint mix_estimate(longint old, longint rate, longint acc_ang);
        longint wg, wa, gterm, sum;
        wg    = longint'(alpha);
        wa    = 65536 - wg;
        gterm = old * 16777216 + rate * longint'(rate_scale);
        sum   = wg * gterm + wa * (acc_ang * 16777216);
        return sat_angle((sum + (longint'(1) <<< 39)) >>> 40);
    endfunction

    // expected result of one request; advances the estimates
    function automatic logic [63:0] predict_tilt(logic [79:0] req);
        logic signed [15:0] w_ax, w_ay, w_az, w_gx, w_gy;
        longint ax, ay, az, gx, gy, acc_roll, acc_pitch;
        w_ax = req[15:0];
        w_ay = req[31:16];
        w_az = req[47:32];
        w_gx = req[63:48];
        w_gy = req[79:64];
        ax = (longint'(w_ax) >>> 2) - longint'(ofs_ax);
        ay = (longint'(w_ay) >>> 2) - longint'(ofs_ay);
        az = (longint'(w_az) >>> 2) - longint'(ofs_az);
        gx = longint'(w_gx) - longint'(ofs_gx);
        gy = longint'(w_gy) - longint'(ofs_gy);
        acc_roll = tilt_atan2(ay, az);
        // pitch reference axis depends on the roll quadrant
        if (acc_roll > itf_pkg::RIGHT_ANG)
            acc_pitch = tilt_atan2(ax, ay);
        else if (acc_roll < -itf_pkg::RIGHT_ANG)
            acc_pitch = tilt_atan2(ax, -az);
        else
            acc_pitch = tilt_atan2(ax, az);
        roll_est  = 16'(mix_estimate(longint'(roll_est), gx, acc_roll));
        pitch_est = 16'(mix_estimate(longint'(pitch_est), gy, acc_pitch));
        return {acc_pitch[15:0], acc_roll[15:0], pitch_est, roll_est};
    endfunction

    task automatic report(string what, logic [15:0] want, logic [15:0] got);
        if (fail_count < MAX_PRINTS)
            $display("ERROR %s at result %0d: expected %0d, got %0d",
                     what, result_idx, $signed(want), $signed(got));
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            alpha      = itf_pkg::ALPHA_RESET;
            rate_scale = itf_pkg::SCALE_RESET;
            ofs_ax     = '0;
            ofs_ay     = '0;
            ofs_az     = '0;
            ofs_gx     = '0;
            ofs_gy     = '0;
            roll_est   = '0;
            pitch_est  = '0;
            result_idx = 0;
            tilt_expect_q.delete();
        end else begin
            // result side
            if (m_tvalid && m_tready) begin
                if (tilt_expect_q.size() == 0) begin
                    report("result with no request pending", '0, m_tdata[15:0]);
                end else begin
                    for (int f = 0; f < 4; f++)
                        if (m_tdata[16*f +: 16] !== tilt_expect_q[0][16*f +: 16])
                            report(field_name[f], tilt_expect_q[0][16*f +: 16],
                                   m_tdata[16*f +: 16]);
                    void'(tilt_expect_q.pop_front());
                end
                result_idx++;
            end
            // request side
            if (s_tvalid && s_tready)
                tilt_expect_q.push_back(predict_tilt(s_tdata));
            // register writes
            if (cfg_we) begin
                case (cfg_index)
                    itf_pkg::CFG_BLEND_ALPHA: alpha      = cfg_data[15:0];
                    itf_pkg::CFG_GYRO_SCALE:  rate_scale = cfg_data[23:0];
                    itf_pkg::CFG_ACC_OFS_X:   ofs_ax     = cfg_data[13:0];
                    itf_pkg::CFG_ACC_OFS_Y:   ofs_ay     = cfg_data[13:0];
                    itf_pkg::CFG_ACC_OFS_Z:   ofs_az     = cfg_data[13:0];
                    itf_pkg::CFG_GYR_OFS_X:   ofs_gx     = cfg_data[15:0];
                    itf_pkg::CFG_GYR_OFS_Y:   ofs_gy     = cfg_data[15:0];
                    default: ;
                endcase
            end
        end
        pending = tilt_expect_q.size();
    end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the tilt filter core. A short directed run covers
// the corner vectors, then several register settings (reset values, pure
// accel blend, extreme gains and offsets, random) each get a burst of random
// requests with random idle gaps on the request side (not in set 1) and random
// stalls on the result side (not in set 4); checked by tilt_filter_checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CORDIC_STEPS   = 16;
    localparam int LIMIT_CYCLES   = 1000000;
    localparam int TAIL_CYCLES    = 60;
    localparam int RANDOM_PER_SET = 68;
    localparam int NUM_SETS       = 6;

    typedef struct packed {
        logic [15:0] alpha;
        logic [23:0] scale;
        logic [13:0] ofs_ax;
        logic [13:0] ofs_ay;
        logic [13:0] ofs_az;
        logic [15:0] ofs_gx;
        logic [15:0] ofs_gy;
    } tilt_cfg_t;

    logic                           aclk;
    logic                           aresetn;
    logic [79:0]                    s_tdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [63:0]                    m_tdata;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic                           cfg_we;
    logic [itf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [itf_pkg::CFG_DATA_W-1:0] cfg_data;

    int        chk_fail;
    int        chk_pending;
    int        cycle_count;
    int        stall_left;
    bit        tx_gaps_on;
    bit        rx_stalls_on;
    tilt_cfg_t cur_cfg;

    imu_tilt_complementary_filter_core #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tilt_filter_checker #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (chk_fail),
        .pending    (chk_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL imu_tilt_complementary_filter_core");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 3);
        if (r < 92) return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    // result side back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
            stall_left = gap_len() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [79:0] pack_request(logic [15:0] ax, logic [15:0] ay,
                                                 logic [15:0] az, logic [15:0] gx,
                                                 logic [15:0] gy);
        return {gy, gx, az, ay, ax};
    endfunction

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic logic [15:0] near_zero(int span);
        return 16'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // random request mix: raw noise, gravity-like tilts, axes cancelled by
    // their offsets, and field extremes
    function automatic logic [79:0] rand_request();
        logic [15:0] w [5];
        int          kind;
        int          axis;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 5; k++) w[k] = 16'($urandom);
        case (kind)
            4, 5, 6: begin
                for (int k = 0; k < 3; k++) w[k] = near_zero(16384);
                w[3] = near_zero(2000);
                w[4] = near_zero(2000);
            end
            7: begin
                axis = $urandom_range(0, 2);
                if (axis == 0) w[0] = {cur_cfg.ofs_ax, 2'($urandom)};
                if (axis == 1) w[1] = {cur_cfg.ofs_ay, 2'($urandom)};
                if (axis == 2) w[2] = {cur_cfg.ofs_az, 2'($urandom)};
            end
            8: for (int k = 0; k < 5; k++) w[k] = pick_extreme();
            9: begin
                w[0] = {cur_cfg.ofs_ax, 2'($urandom)};
                w[1] = {cur_cfg.ofs_ay, 2'($urandom)};
                w[2] = {cur_cfg.ofs_az, 2'($urandom)};
            end
            default: ;
        endcase
        return pack_request(w[0], w[1], w[2], w[3], w[4]);
    endfunction

    // present one request and wait for its handshake; valid stays high
    task automatic send_request(logic [79:0] req);
        int gap;
        gap = (tx_gaps_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (chk_pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(logic [itf_pkg::CFG_IDX_W-1:0] idx, logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
    endtask

    task automatic program_regs(tilt_cfg_t c);
        write_reg(itf_pkg::CFG_BLEND_ALPHA, 24'(c.alpha));
        write_reg(itf_pkg::CFG_GYRO_SCALE,  c.scale);
        write_reg(itf_pkg::CFG_ACC_OFS_X,   24'(c.ofs_ax));
        write_reg(itf_pkg::CFG_ACC_OFS_Y,   24'(c.ofs_ay));
        write_reg(itf_pkg::CFG_ACC_OFS_Z,   24'(c.ofs_az));
        write_reg(itf_pkg::CFG_GYR_OFS_X,   24'(c.ofs_gx));
        write_reg(itf_pkg::CFG_GYR_OFS_Y,   24'(c.ofs_gy));
        cfg_we  <= 1'b0;
        cur_cfg = c;
    endtask

    initial begin
        tilt_cfg_t c;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        cur_cfg      = '{alpha: itf_pkg::ALPHA_RESET, scale: itf_pkg::SCALE_RESET,
                         default: '0};
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed corners at reset register values
        send_request(pack_request(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_request(pack_request(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_request(pack_request(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        // y zero, z negative: exactly 180 degrees
        send_request(pack_request(16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000));
        // y just below zero, z negative: just above -180
        send_request(pack_request(16'h0000, 16'hFFFC, 16'hC000, 16'h0000, 16'h0000));
        // roll beyond +90: pitch against y
        send_request(pack_request(16'h1F40, 16'h4000, 16'hC000, 16'h0100, 16'hFF00));
        // roll beyond -90: pitch against -z
        send_request(pack_request(16'hE0C0, 16'hC000, 16'hC000, 16'hFF00, 16'h0100));
        // roll near +-90 with z zero
        send_request(pack_request(16'h0FA0, 16'h4000, 16'h0000, 16'h0000, 16'h0000));
        send_request(pack_request(16'hF060, 16'hC000, 16'h0000, 16'h0000, 16'h0000));
        send_request(pack_request(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_request(pack_request(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000));
        send_request(pack_request(16'hC000, 16'h0000, 16'h4000, 16'h0000, 16'h0000));
        // small words that shift to zero or minus one
        send_request(pack_request(16'h0003, 16'h0003, 16'h0003, 16'h0001, 16'h0001));
        send_request(pack_request(16'hFFFD, 16'h0003, 16'h0003, 16'hFFFF, 16'hFFFF));
        send_request(pack_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        // gyro extremes on a level sensor
        send_request(pack_request(16'h0000, 16'h0000, 16'h4000, 16'h7FFF, 16'h8000));
        send_request(pack_request(16'h0000, 16'h0000, 16'h4000, 16'h8000, 16'h7FFF));
        send_request(pack_request(16'h7FFF, 16'h8000, 16'h0000, 16'h5555, 16'hAAAA));

        for (int set_no = 0; set_no < NUM_SETS; set_no++) begin
            wait_idle();
            case (set_no)
                0: c = '{alpha: itf_pkg::ALPHA_RESET, scale: itf_pkg::SCALE_RESET,
                         default: '0};
                // accel angle only, no gyro contribution
                1: c = '{alpha: 16'h0000, scale: 24'h000000, default: '0};
                // maximum gyro weight and gain, top offsets
                2: c = '{alpha: 16'hFFFF, scale: 24'hFFFFFF, ofs_ax: 14'h1FFF,
                         ofs_ay: 14'h1FFF, ofs_az: 14'h1FFF, ofs_gx: 16'h7FFF,
                         ofs_gy: 16'h7FFF};
                // bottom offsets
                3: c = '{alpha: 16'h0001, scale: 24'h000001, ofs_ax: 14'h2000,
                         ofs_ay: 14'h2000, ofs_az: 14'h2000, ofs_gx: 16'h8000,
                         ofs_gy: 16'h8000};
                default: c = '{alpha: 16'($urandom), scale: 24'($urandom),
                               ofs_ax: 14'($urandom), ofs_ay: 14'($urandom),
                               ofs_az: 14'($urandom), ofs_gx: 16'($urandom),
                               ofs_gy: 16'($urandom)};
            endcase
            program_regs(c);
            tx_gaps_on   = (set_no != 1);
            rx_stalls_on = (set_no != 4);

            send_request(pack_request(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
            send_request(pack_request(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
            send_request(pack_request({c.ofs_ax, 2'b00}, {c.ofs_ay, 2'b00},
                                      {c.ofs_az, 2'b00}, c.ofs_gx, c.ofs_gy));
            for (int n = 0; n < RANDOM_PER_SET; n++)
                send_request(rand_request());
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (chk_fail == 0 && chk_pending == 0) begin
            $display("PASS imu_tilt_complementary_filter_core");
        end else begin
            $display("FAIL imu_tilt_complementary_filter_core");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/itf_pkg.sv
hw/rtl/itf_cordic.sv
hw/rtl/itf_datapath.sv
hw/rtl/itf_ctrl.sv
hw/rtl/imu_tilt_complementary_filter_core.sv
tb/tilt_filter_checker.sv
tb/tb_top.sv
